>>> hw/rtl/iapw_pkg.sv
`default_nettype none

package iapw_pkg;

    localparam int MAX_SOURCE_SIDE = 64;
    localparam int OUT_COORD_BITS  = 10;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int SIDE_W    = $clog2(MAX_SOURCE_SIDE);
    localparam int SIZE_W    = $clog2(MAX_SOURCE_SIDE + 1);
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int MEM_DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
    localparam int LIMIT_W   = SIZE_W + FRAC_BITS;

    // coefficient (signed) times coordinate (zero extended)
    localparam int PROD_W = COEF_W + OUT_COORD_BITS + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    // input word layout, lowest bits first
    localparam int IN_COL_LSB   = 0;
    localparam int IN_ROW_LSB   = IN_COL_LSB + SIDE_W;
    localparam int IN_RED_LSB   = IN_ROW_LSB + SIDE_W;
    localparam int IN_GREEN_LSB = IN_RED_LSB + CHAN_W;
    localparam int IN_BLUE_LSB  = IN_GREEN_LSB + CHAN_W;
    localparam int IN_OCOL_LSB  = IN_BLUE_LSB + CHAN_W;
    localparam int IN_OROW_LSB  = IN_OCOL_LSB + OUT_COORD_BITS;
    localparam int IN_BITS      = IN_OROW_LSB + OUT_COORD_BITS;
    localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((RGB_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_MAP  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_SIZE     = 3'd6,
        REG_BG       = 3'd7
    } reg_idx_t;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(33);
    localparam logic [CHAN_W-1:0] BG_RESET   = CHAN_W'(50);
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] offset_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] offset_y;
        logic [LIMIT_W-1:0]       limit;     // (side - 1) in unsigned Q7.16
        logic [CHAN_W-1:0]        bg_level;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/iapw_cfg.sv
`default_nettype none

module iapw_cfg
    import iapw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic signed [COEF_W-1:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic signed [COEF_W-1:0] coef_yx_reg, coef_yy_reg, offset_y_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [CHAN_W-1:0]        bg_reg;
    logic [SIZE_W-1:0]        side_eff;
    logic [SIZE_W-1:0]        side_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg  <= COEF_ONE;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= COEF_ONE;
            offset_y_reg <= '0;
            size_reg     <= SIZE_RESET;
            bg_reg       <= BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COEF_XX:  coef_xx_reg  <= cfg_data;
                REG_COEF_XY:  coef_xy_reg  <= cfg_data;
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_COEF_YX:  coef_yx_reg  <= cfg_data;
                REG_COEF_YY:  coef_yy_reg  <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_SIZE:     size_reg     <= cfg_data[SIZE_W-1:0];
                REG_BG:       bg_reg       <= cfg_data[CHAN_W-1:0];
                default:      ;
            endcase
        end
    end

    // side clamped to 1 .. MAX_SOURCE_SIDE
    always_comb
    begin
        if (size_reg == '0)
            side_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(MAX_SOURCE_SIDE))
            side_eff = SIZE_W'(MAX_SOURCE_SIDE);
        else
            side_eff = size_reg;
        side_m1 = side_eff - SIZE_W'(1);
    end

    assign cfg.coef_xx  = coef_xx_reg;
    assign cfg.coef_xy  = coef_xy_reg;
    assign cfg.offset_x = offset_x_reg;
    assign cfg.coef_yx  = coef_yx_reg;
    assign cfg.coef_yy  = coef_yy_reg;
    assign cfg.offset_y = offset_y_reg;
    assign cfg.limit    = {side_m1, {FRAC_BITS{1'b0}}};
    assign cfg.bg_level = bg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/inverse_affine_pixel_warp.sv
// Channel  Dir  Signals                           Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser  load or map command word
// m_*      out  m_tvalid m_tready m_tdata m_tuser  mapped pixel word
// cfg_*    in   cfg_we cfg_index cfg_data          register writes
//
// Four stages: multiply, sum, compare + source RAM read, output register.
// One word per cycle while m_tready holds; a map word reaches m_* through the stage registers, loads give none.
// Loads write the RAM at stage 3, in order with map reads at the same stage.
// Each stage holds only when it is full and the one after it holds.
// rst_n clears valids and resets config registers; RAM content is undefined until loaded.
`default_nettype none

module inverse_affine_pixel_warp
    import iapw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // col, row, load_red, load_green, load_blue, out_col, out_row
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_red, pixel_green, pixel_blue
    output logic [M_TDATA_W-1:0]       m_tdata,
    // inside_source
    output logic                       m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    iapw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    logic                      map1_reg, map2_reg;
    logic [ADDR_W-1:0]         waddr1_reg, waddr2_reg;
    logic [RGB_W-1:0]          wdata1_reg, wdata2_reg;
    logic signed [PROD_W-1:0]  pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg;
    logic signed [SUM_W-1:0]   sx_next, sy_next;
    logic [OUT_COORD_BITS-1:0] ocol, orow;

    logic                      inside_next, inside3_reg, inside4_reg;
    logic [SUM_W-1:0]          lim_ext;
    logic [ADDR_W-1:0]         raddr;
    logic                      mem_we;
    logic [RGB_W-1:0]          rd_data_reg;
    logic [RGB_W-1:0]          pix_reg;
    logic [RGB_W-1:0]          src_mem [0:MEM_DEPTH-1];

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    assign v1_next = en1 ? s_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? (v2_reg && map2_reg) : v3_reg;
    assign v4_next = en4 ? v3_reg : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // stage 1: products
    assign ocol = s_tdata[IN_OCOL_LSB +: OUT_COORD_BITS];
    assign orow = s_tdata[IN_OROW_LSB +: OUT_COORD_BITS];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            map1_reg   <= (cmd_t'(s_tuser) == CMD_MAP);
            waddr1_reg <= {s_tdata[IN_ROW_LSB +: SIDE_W], s_tdata[IN_COL_LSB +: SIDE_W]};
            wdata1_reg <= {s_tdata[IN_BLUE_LSB +: CHAN_W], s_tdata[IN_GREEN_LSB +: CHAN_W],
                           s_tdata[IN_RED_LSB +: CHAN_W]};
            pxx_reg    <= cfg.coef_xx * $signed({1'b0, ocol});
            pxy_reg    <= cfg.coef_xy * $signed({1'b0, orow});
            pyx_reg    <= cfg.coef_yx * $signed({1'b0, ocol});
            pyy_reg    <= cfg.coef_yy * $signed({1'b0, orow});
        end
    end

    // stage 2: sums
    assign sx_next = SUM_W'(pxx_reg) + SUM_W'(pxy_reg) + SUM_W'(cfg.offset_x);
    assign sy_next = SUM_W'(pyx_reg) + SUM_W'(pyy_reg) + SUM_W'(cfg.offset_y);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            map2_reg   <= map1_reg;
            waddr2_reg <= waddr1_reg;
            wdata2_reg <= wdata1_reg;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
        end
    end

    // stage 3: range check, RAM write or read
    assign lim_ext = SUM_W'(cfg.limit);
    assign inside_next = !sx_reg[SUM_W-1] && ($unsigned(sx_reg) <= lim_ext) &&
                         !sy_reg[SUM_W-1] && ($unsigned(sy_reg) <= lim_ext);
    assign raddr  = {sy_reg[FRAC_BITS +: SIDE_W], sx_reg[FRAC_BITS +: SIDE_W]};
    assign mem_we = en3 && v2_reg && !map2_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            src_mem[waddr2_reg] <= wdata2_reg;
        if (en3)
            rd_data_reg <= src_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            inside3_reg <= inside_next;
    end

    // stage 4: output register
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            inside4_reg <= inside3_reg;
            pix_reg     <= inside3_reg ? rd_data_reg
                                       : {cfg.bg_level, cfg.bg_level, cfg.bg_level};
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = M_TDATA_W'(pix_reg);
    assign m_tuser  = inside4_reg;

endmodule

`default_nettype wire

>>> tb/sv/inverse_affine_pixel_warp_tb.sv
`timescale 1ns / 100ps

module inverse_affine_pixel_warp_tb;
    import iapw_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              from_src;
    } pixel_t;

    class warp_scoreboard;
        logic [RGB_W-1:0]  pixels [MEM_DEPTH];
        bit                written [MEM_DEPTH];
        longint            c_xx, c_xy, off_x, c_yx, c_yy, off_y;
        int                side_cfg;
        logic [CHAN_W-1:0] bg_cfg;
        pixel_t            pending_pixels [$];
        int                errors;

        function new();
            c_xx = 65536;
            c_xy = 0;
            off_x = 0;
            c_yx = 0;
            c_yy = 65536;
            off_y = 0;
            side_cfg = 33;
            bg_cfg = BG_RESET;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_COEF_XX:  c_xx = $signed(v);
                REG_COEF_XY:  c_xy = $signed(v);
                REG_OFFSET_X: off_x = $signed(v);
                REG_COEF_YX:  c_yx = $signed(v);
                REG_COEF_YY:  c_yy = $signed(v);
                REG_OFFSET_Y: off_y = $signed(v);
                REG_SIZE:     side_cfg = int'(v[SIZE_W-1:0]);
                REG_BG:       bg_cfg = v[CHAN_W-1:0];
                default:      ;
            endcase
        endfunction

        // source coordinate test; addr valid only when inside
        function bit source_hit(logic [OUT_COORD_BITS-1:0] oc, logic [OUT_COORD_BITS-1:0] orw,
                                output int addr);
            longint sx, sy, limit;
            int     side;
            sx = c_xx * longint'(oc) + c_xy * longint'(orw) + off_x;
            sy = c_yx * longint'(oc) + c_yy * longint'(orw) + off_y;
            side = side_cfg;
            if (side == 0)
                side = 1;
            if (side > MAX_SOURCE_SIDE)
                side = MAX_SOURCE_SIDE;
            limit = longint'(side - 1) <<< FRAC_BITS;
            addr = 0;
            if (sx < 0 || sx > limit || sy < 0 || sy > limit)
                return 1'b0;
            addr = int'((sy >>> FRAC_BITS) * MAX_SOURCE_SIDE + (sx >>> FRAC_BITS));
            return 1'b1;
        endfunction

        function pixel_t warp_lookup(logic [OUT_COORD_BITS-1:0] oc,
                                     logic [OUT_COORD_BITS-1:0] orw);
            pixel_t p;
            int     addr;
            if (source_hit(oc, orw, addr))
            begin
                p.red      = pixels[addr][23:16];
                p.green    = pixels[addr][15:8];
                p.blue     = pixels[addr][7:0];
                p.from_src = 1'b1;
            end
            else
            begin
                p.red      = bg_cfg;
                p.green    = bg_cfg;
                p.blue     = bg_cfg;
                p.from_src = 1'b0;
            end
            return p;
        endfunction

        function void note_input(cmd_t cmd, logic [S_TDATA_W-1:0] w);
            int addr;
            if (cmd == CMD_LOAD)
            begin
                addr = int'(w[IN_ROW_LSB +: SIDE_W]) * MAX_SOURCE_SIDE
                     + int'(w[IN_COL_LSB +: SIDE_W]);
                pixels[addr] = {w[IN_RED_LSB +: CHAN_W], w[IN_GREEN_LSB +: CHAN_W],
                                w[IN_BLUE_LSB +: CHAN_W]};
                written[addr] = 1'b1;
            end
            else
            begin
                pending_pixels.push_back(warp_lookup(w[IN_OCOL_LSB +: OUT_COORD_BITS],
                                                     w[IN_OROW_LSB +: OUT_COORD_BITS]));
            end
        endfunction

        task check_result(logic [M_TDATA_W-1:0] d, logic from_src);
            pixel_t want, got;
            got.red      = d[7:0];
            got.green    = d[15:8];
            got.blue     = d[23:16];
            got.from_src = from_src;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel word rgb=%h src=%b", d, from_src));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.red != want.red || got.green != want.green || got.blue != want.blue
                    || got.from_src != want.from_src)
                report($sformatf("pixel r/g/b/src got %h/%h/%h/%b want %h/%h/%h/%b",
                                 got.red, got.green, got.blue, got.from_src,
                                 want.red, want.green, want.blue, want.from_src));
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    warp_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             map_window = 63;

    inverse_affine_pixel_warp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [S_TDATA_W-1:0] pack_word(
        logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row,
        logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
        logic [OUT_COORD_BITS-1:0] oc, logic [OUT_COORD_BITS-1:0] orw);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[IN_COL_LSB +: SIDE_W] = col;
        w[IN_ROW_LSB +: SIDE_W] = row;
        w[IN_RED_LSB +: CHAN_W] = r;
        w[IN_GREEN_LSB +: CHAN_W] = g;
        w[IN_BLUE_LSB +: CHAN_W] = b;
        w[IN_OCOL_LSB +: OUT_COORD_BITS] = oc;
        w[IN_OROW_LSB +: OUT_COORD_BITS] = orw;
        return w;
    endfunction

    task automatic send_word(cmd_t cmd, logic [S_TDATA_W-1:0] w);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(cmd, w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic load_pixel(int col, int row, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b);
        send_word(CMD_LOAD, pack_word(SIDE_W'(col), SIDE_W'(row), r, g, b,
                                      OUT_COORD_BITS'($urandom), OUT_COORD_BITS'($urandom)));
    endtask

    // never let a map sample an entry that was not loaded yet
    task automatic map_pixel(int oc, int orw);
        int addr;
        if (sb.source_hit(OUT_COORD_BITS'(oc), OUT_COORD_BITS'(orw), addr) && !sb.written[addr])
            load_pixel(addr % MAX_SOURCE_SIDE, addr / MAX_SOURCE_SIDE,
                       CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        send_word(CMD_MAP, pack_word(SIDE_W'($urandom), SIDE_W'($urandom),
                                     CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                                     OUT_COORD_BITS'(oc), OUT_COORD_BITS'(orw)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] xx, logic [31:0] xy, logic [31:0] ox,
                             logic [31:0] yx, logic [31:0] yy, logic [31:0] oy,
                             logic [31:0] size, logic [31:0] bg);
        drain();
        write_reg(REG_COEF_XX, xx);
        write_reg(REG_COEF_XY, xy);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_COEF_YX, yx);
        write_reg(REG_COEF_YY, yy);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_SIZE, size);
        write_reg(REG_BG, bg);
        cfg_we <= 1'b0;
    endtask

    // scale with shear and optional vertical mirror, or plain noise coefficients
    task automatic random_config(bit noise);
        int side, s, xy, yx, yy, ox, oy, w;
        if (noise)
        begin
            map_window = 1023;
            configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 127), $urandom_range(0, 255));
        end
        else
        begin
            case ($urandom_range(3))
                0:       side = 1;
                1:       side = MAX_SOURCE_SIDE;
                default: side = $urandom_range(2, MAX_SOURCE_SIDE);
            endcase
            s = $urandom_range(32'h2000, 32'h30000);
            xy = $urandom_range(0, s / 2);
            if ($urandom_range(1))
                xy = -xy;
            yx = $urandom_range(0, s / 2);
            if ($urandom_range(1))
                yx = -yx;
            ox = int'($urandom_range(0, side * 65536)) - side * 32768;
            yy = s;
            oy = int'($urandom_range(0, side * 65536)) - side * 32768;
            if ($urandom_range(3) == 0)
            begin
                yy = -s;
                oy = side * 65536 - int'($urandom_range(0, side * 32768));
            end
            w = (side * 65536 / s) * 3 / 2 + 2;
            if (w > 1023)
                w = 1023;
            map_window = w;
            configure(s, xy, ox, yx, yy, oy, side, $urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int phase, i, wait_cycles;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: identity, 33 x 33, grey 50
        load_pixel(0, 0, 8'h00, 8'h00, 8'h00);
        load_pixel(63, 63, 8'hFF, 8'hFF, 8'hFF);
        load_pixel(32, 32, 8'h12, 8'h34, 8'h56);
        map_pixel(0, 0);
        map_pixel(32, 32);
        map_pixel(33, 32);
        map_pixel(32, 33);
        map_pixel(1023, 1023);
        map_pixel(0, 1023);
        map_pixel(1023, 0);

        configure(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 64, 0);
        map_pixel(63, 63);
        map_pixel(64, 63);

        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 8'hFF);
        map_pixel(0, 0);
        map_pixel(1, 1);
        map_pixel(1023, 0);
        map_pixel(0, 1023);
        map_pixel(1023, 1023);

        // size 0 acts as 1: only exact zero is inside
        configure(0, 0, 32'h0000_FFFF, 0, 0, 0, 0, 8'h55);
        map_pixel(5, 5);
        configure(0, 0, 0, 0, 0, 0, 0, 8'h55);
        map_pixel(7, 9);

        // size above the store clamps to 64: upper edge exact
        configure(0, 0, 63 << 16, 0, 0, 63 << 16, 127, 8'hAA);
        map_pixel(0, 0);
        configure(0, 0, (63 << 16) + 1, 0, 0, 63 << 16, 127, 8'hAA);
        map_pixel(0, 0);
        configure(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 127, 8'hAA);
        map_pixel(0, 0);

        for (phase = 0; phase < 8; phase++)
        begin
            random_config(phase == 5);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase
            for (i = 0; i < 160; i++)
            begin
                if (i == 60)
                    drain();
                if ($urandom_range(99) < 30)
                    load_pixel($urandom_range(0, 63), $urandom_range(0, 63),
                               CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
                else if ($urandom_range(99) < 10)
                    map_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    map_pixel($urandom_range(0, map_window), $urandom_range(0, map_window));
            end
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixel words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("inverse_affine_pixel_warp_tb: done, clean");
        else
            $display("inverse_affine_pixel_warp_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ERROR: timeout");
        $display("inverse_affine_pixel_warp_tb: done, errors");
        $finish;
    end

endmodule
